FILE: rtl/cbe_pkg.sv
package cbe_pkg;

    // Default pipeline shape.
    localparam int unsigned BISECTION_STEPS = 21;
    localparam int unsigned FRAC_BITS       = 16;

    // Width of every external Q0.16 field.
    localparam int unsigned FIELD_W = 17;
    localparam logic [FIELD_W-1:0] Q16_ONE = 17'h10000;

    // Register reset values.
    localparam logic [FIELD_W-1:0] RST_X1 = 17'd54395;
    localparam logic [FIELD_W-1:0] RST_Y1 = 17'd0;
    localparam logic [FIELD_W-1:0] RST_X2 = 17'd11141;
    localparam logic [FIELD_W-1:0] RST_Y2 = 17'd65536;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X1 = 2'd0,
        REG_Y1 = 2'd1,
        REG_X2 = 2'd2,
        REG_Y2 = 2'd3
    } t_cfg_idx;

    // Saturate a Q0.16 field to 1.0.
    function automatic logic [FIELD_W-1:0] sat_q16(input logic [FIELD_W-1:0] v);
        sat_q16 = (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage

FILE: rtl/cbe_curve.sv
// One evaluation of B(u) = 3*vv*u*p1 + 3*v*uu*p2 + uu*u in Q0.F, saturated to 1.0.
// Four register stages, one multiplier level per stage.
// All stages advance together under i_en; side data rides along in i_tag.
// The valid bit travels beside the tag and is cleared by reset.
module cbe_curve #(
    parameter int unsigned F     = cbe_pkg::FRAC_BITS,
    parameter int unsigned TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [F:0]       i_u,
    input  logic [F:0]       i_p1,
    input  logic [F:0]       i_p2,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [F:0]       o_b,
    output logic [TAG_W-1:0] o_tag
);
    localparam int unsigned W = F + 1;
    localparam logic [2*W-1:0] RND = (2*W)'(1) << (F - 1);
    localparam logic [W-1:0] ONE = W'(1) << F;

    // Valid bits, one per stage.
    logic r_vld1, r_vld2, r_vld3, r_vld4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    // Stage 1: v*v and u*u.
    logic [W-1:0] r_u1, r_v1, r_vv1, r_uu1, r_p1_1, r_p2_1;
    logic [TAG_W-1:0] r_t1;
    logic [W-1:0] v0;
    logic [2*W-1:0] vv_f, uu_f;
    assign v0   = ONE - i_u;
    assign vv_f = v0 * v0 + RND;
    assign uu_f = i_u * i_u + RND;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1   <= i_u;
            r_v1   <= v0;
            r_vv1  <= W'(vv_f >> F);
            r_uu1  <= W'(uu_f >> F);
            r_p1_1 <= i_p1;
            r_p2_1 <= i_p2;
            r_t1   <= i_tag;
        end
    end

    // Stage 2: vv*u, v*uu, uu*u.
    logic [W-1:0] r_a2, r_b2, r_c2, r_p1_2, r_p2_2;
    logic [TAG_W-1:0] r_t2;
    logic [2*W-1:0] a_f, b_f, c_f;
    assign a_f = r_vv1 * r_u1 + RND;
    assign b_f = r_v1 * r_uu1 + RND;
    assign c_f = r_uu1 * r_u1 + RND;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2   <= W'(a_f >> F);
            r_b2   <= W'(b_f >> F);
            r_c2   <= W'(c_f >> F);
            r_p1_2 <= r_p1_1;
            r_p2_2 <= r_p2_1;
            r_t2   <= r_t1;
        end
    end

    // Stage 3: products with the control values.
    logic [W-1:0] r_a3, r_b3, r_c3;
    logic [TAG_W-1:0] r_t3;
    logic [2*W-1:0] a3_f, b3_f;
    assign a3_f = r_a2 * r_p1_2 + RND;
    assign b3_f = r_b2 * r_p2_2 + RND;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a3 <= W'(a3_f >> F);
            r_b3 <= W'(b3_f >> F);
            r_c3 <= r_c2;
            r_t3 <= r_t2;
        end
    end

    // Stage 4: weighted sum and saturation.
    logic [W-1:0] r_b4;
    logic [TAG_W-1:0] r_t4;
    logic [W+2:0] sum;
    assign sum = (W+3)'(3) * ((W+3)'(r_a3) + (W+3)'(r_b3)) + (W+3)'(r_c3);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b4 <= (sum > (W+3)'(ONE)) ? ONE : W'(sum);
            r_t4 <= r_t3;
        end
    end

    assign o_vld = r_vld4;
    assign o_b   = r_b4;
    assign o_tag = r_t4;
endmodule

FILE: rtl/cubic_bezier_easing_top.sv
// Each bisection step and the final y evaluation is a four-stage curve unit, the
// last feeding the output register. Throughput: one item per cycle; the whole
// pipeline stalls only when the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and loads the control
// registers with their defaults.
module cubic_bezier_easing_top #(
    parameter int unsigned BISECTION_STEPS = cbe_pkg::BISECTION_STEPS,
    parameter int unsigned FRAC_BITS       = cbe_pkg::FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [cbe_pkg::FIELD_W-1:0]    i_progress,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [cbe_pkg::FIELD_W-1:0]    o_eased_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbe_pkg::FIELD_W-1:0]    i_cfg_data
);
    localparam int unsigned F   = FRAC_BITS;
    localparam int unsigned W   = F + 1;
    localparam int unsigned FW  = cbe_pkg::FIELD_W;
    localparam int unsigned N   = BISECTION_STEPS;
    localparam logic [W-1:0] ONE = W'(1) << F;
    // Tag: t, lo, hi, mid.
    localparam int unsigned TAG_W = 4 * W;

    // Configuration registers.
    logic [FW-1:0] r_x1, r_y1, r_x2, r_y2;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= cbe_pkg::RST_X1;
            r_y1 <= cbe_pkg::RST_Y1;
            r_x2 <= cbe_pkg::RST_X2;
            r_y2 <= cbe_pkg::RST_Y2;
        end else if (i_cfg_valid) begin
            unique case (cbe_pkg::t_cfg_idx'(i_cfg_index))
                cbe_pkg::REG_X1: r_x1 <= i_cfg_data;
                cbe_pkg::REG_Y1: r_y1 <= i_cfg_data;
                cbe_pkg::REG_X2: r_x2 <= i_cfg_data;
                cbe_pkg::REG_Y2: r_y2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Q0.16 to Q0.F conversion.
    function automatic logic [W-1:0] to_int(input logic [FW-1:0] v);
        logic [FW-1:0] s;
        s = cbe_pkg::sat_q16(v);
        if (F >= 16) to_int = W'({s, 24'b0} >> (24 - (F - 16)));
        else         to_int = W'(s >> (16 - F));
    endfunction

    logic [W-1:0] x1, x2, y1, y2;
    assign x1 = to_int(r_x1);
    assign x2 = to_int(r_x2);
    assign y1 = to_int(r_y1);
    assign y2 = to_int(r_y2);

    // Global advance: the output register can take a new value.
    logic r_out_v;
    logic adv;
    assign adv     = !r_out_v || i_ready;
    assign o_ready = adv;

    // Bisection chain: step k evaluates X at the midpoint of its bounds.
    logic [TAG_W-1:0] tag_in  [N+1];
    logic [TAG_W-1:0] tag_out [N+1];
    logic [W-1:0]     b_out   [N+1];
    logic             vld_in  [N+1];
    logic             vld_out [N+1];

    logic [W-1:0] t0;
    assign t0 = to_int(i_progress);
    assign tag_in[0] = {t0, {W{1'b0}}, ONE, ONE >> 1};
    assign vld_in[0] = i_valid;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [W-1:0] mid;
        assign mid = tag_in[k][W-1:0];
        cbe_curve #(.F(F), .TAG_W(TAG_W)) u_curve (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_vld   (vld_in[k]),
            .i_u     (mid),
            .i_p1    (x1),
            .i_p2    (x2),
            .i_tag   (tag_in[k]),
            .o_vld   (vld_out[k]),
            .o_b     (b_out[k]),
            .o_tag   (tag_out[k])
        );
        // Narrow the interval and form the next midpoint.
        logic [W-1:0]  t_k, lo_k, hi_k, m_k, lo_n, hi_n;
        logic [W:0]    s_n;
        assign {t_k, lo_k, hi_k, m_k} = tag_out[k];
        assign lo_n = (b_out[k] < t_k) ? m_k : lo_k;
        assign hi_n = (b_out[k] < t_k) ? hi_k : m_k;
        assign s_n  = {1'b0, lo_n} + {1'b0, hi_n};
        assign vld_in[k+1] = vld_out[k];
        assign tag_in[k+1] = (k == N - 1) ? {t_k, lo_n, hi_n, m_k}
                                          : {t_k, lo_n, hi_n, W'(s_n >> 1)};
    end

    // Final y evaluation at the last midpoint.
    cbe_curve #(.F(F), .TAG_W(TAG_W)) u_curve_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (vld_in[N]),
        .i_u     (tag_in[N][W-1:0]),
        .i_p1    (y1),
        .i_p2    (y2),
        .i_tag   (tag_in[N]),
        .o_vld   (vld_out[N]),
        .o_b     (b_out[N]),
        .o_tag   (tag_out[N])
    );

    // Q0.F to Q0.16 with rounding and saturation.
    logic [W+16:0] yw;
    logic [FW-1:0] y16;
    always_comb begin
        if (F > 16) yw = ((W+17)'(b_out[N]) + ((W+17)'(1) << (F - 17))) >> (F - 16);
        else        yw = (W+17)'(b_out[N]) << (16 - F);
        y16 = (yw > (W+17)'(cbe_pkg::Q16_ONE)) ? cbe_pkg::Q16_ONE : FW'(yw);
    end

    // Output register.
    logic [FW-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= vld_out[N];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= y16;
        end
    end

    assign o_valid       = r_out_v;
    assign o_eased_value = r_out;
endmodule

FILE: tb/tb_cubic_bezier_easing_top.sv
module tb_cubic_bezier_easing_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbe_pkg::*;

    localparam int unsigned STEPS   = BISECTION_STEPS;
    localparam int unsigned LATENCY = 4 * (STEPS + 1);

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [FIELD_W-1:0]   i_progress;
    logic                 o_valid;
    logic                 i_ready;
    logic [FIELD_W-1:0]   o_eased_value;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FIELD_W-1:0]   i_cfg_data;

    cubic_bezier_easing_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_progress(i_progress),
        .o_valid(o_valid), .i_ready(i_ready), .o_eased_value(o_eased_value),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the control registers.
    logic [FIELD_W-1:0] shadow_x1, shadow_y1, shadow_x2, shadow_y2;

    logic [FIELD_W-1:0] pending_progress[$];
    logic [FIELD_W-1:0] expected_eased[$];
    int unsigned mismatch_count;
    int unsigned checked_count;
    int unsigned config_count;
    bit          stim_done;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] fx_product(logic [63:0] a, logic [63:0] b);
        return (a * b + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    // Curve value at parameter u for control ordinates p1 and p2.
    function automatic logic [63:0] bezier_at(logic [63:0] u, logic [63:0] p1,
                                              logic [63:0] p2);
        logic [63:0] one, v, vv, uu, s;
        one = 64'd1 << FRAC_BITS;
        v   = one - u;
        vv  = fx_product(v, v);
        uu  = fx_product(u, u);
        s   = 3 * fx_product(fx_product(vv, u), p1)
            + 3 * fx_product(fx_product(v, uu), p2)
            + fx_product(uu, u);
        return (s > one) ? one : s;
    endfunction

    function automatic logic [63:0] clamp_one(logic [FIELD_W-1:0] v);
        return (v > Q16_ONE) ? 64'(Q16_ONE) : 64'(v);
    endfunction

    // Solve x(u) = t by bisection, then evaluate y at the final midpoint.
    function automatic logic [FIELD_W-1:0] ease_progress(logic [FIELD_W-1:0] prog);
        logic [63:0] t, lo, hi, mid, y;
        t   = clamp_one(prog);
        lo  = 0;
        hi  = 64'h10000;
        mid = hi >> 1;
        for (int i = 0; i < STEPS; i++) begin
            mid = (lo + hi) >> 1;
            if (bezier_at(mid, clamp_one(shadow_x1), clamp_one(shadow_x2)) < t)
                lo = mid;
            else
                hi = mid;
        end
        y = bezier_at(mid, clamp_one(shadow_y1), clamp_one(shadow_y2));
        if (y > 64'h10000) y = 64'h10000;
        return y[FIELD_W-1:0];
    endfunction

    // Random gap: mostly zero or short, occasionally long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Input driver: each transfer predicts its result from the current shadow.
    int unsigned drive_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_progress <= '0;
            drive_gap  <= 0;
        end else if (i_valid && !o_ready) begin
            // Hold the item until the transfer.
        end else begin
            if (i_valid) expected_eased.push_back(ease_progress(i_progress));
            if (drive_gap != 0) begin
                drive_gap <= drive_gap - 1;
                i_valid   <= 1'b0;
            end else if (pending_progress.size() != 0) begin
                i_valid    <= 1'b1;
                i_progress <= pending_progress.pop_front();
                drive_gap  <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output monitor with random back pressure.
    int unsigned stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                checked_count <= checked_count + 1;
                if (expected_eased.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result eased_value=%0d", o_eased_value);
                end else begin
                    logic [FIELD_W-1:0] want;
                    want = expected_eased.pop_front();
                    if (want !== o_eased_value) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("eased_value mismatch: expected %0d, got %0d",
                                     want, o_eased_value);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready    <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // Register write over the configuration channel, done while idle.
    task automatic write_reg(t_cfg_idx idx, logic [FIELD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_X1: shadow_x1 = data;
            REG_Y1: shadow_y1 = data;
            REG_X2: shadow_x2 = data;
            default: shadow_y2 = data;
        endcase
        config_count++;
    endtask

    task automatic drain();
        wait (pending_progress.size() == 0 && !i_valid && expected_eased.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_controls(logic [FIELD_W-1:0] x1, logic [FIELD_W-1:0] y1,
                                 logic [FIELD_W-1:0] x2, logic [FIELD_W-1:0] y2);
        drain();
        write_reg(REG_X1, x1);
        write_reg(REG_Y1, y1);
        write_reg(REG_X2, x2);
        write_reg(REG_Y2, y2);
    endtask

    // Random progress: mostly in range, some above 1.0 and at the edges.
    function automatic logic [FIELD_W-1:0] pick_progress();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return FIELD_W'($urandom_range(65536));
        if (r < 90) return FIELD_W'($urandom_range(131071, 65537));
        if (r < 95) return FIELD_W'($urandom_range(3));
        return FIELD_W'($urandom_range(65536, 65533));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_control();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) return FIELD_W'($urandom_range(65536));
        if (r < 85) return FIELD_W'($urandom_range(131071, 65537));
        if (r < 92) return '0;
        return Q16_ONE;
    endfunction

    // Stimulus sequence.
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_progress     = '0;
        i_ready        = 1'b0;
        mismatch_count = 0;
        checked_count  = 0;
        config_count   = 0;
        stim_done      = 1'b0;
        shadow_x1 = RST_X1;
        shadow_y1 = RST_Y1;
        shadow_x2 = RST_X2;
        shadow_y2 = RST_Y2;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed values under the reset curve: edges, midpoint, above 1.0.
        pending_progress = {17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536,
                            17'd65537, 17'd131071, 17'd21845, 17'd43690, 17'h15555};

        // Linear curve and extreme controls, including values above 1.0.
        load_controls(17'd0, 17'd0, Q16_ONE, Q16_ONE);
        pending_progress = {17'd0, 17'd16384, 17'd49152, 17'd65536, 17'd100000};
        load_controls(Q16_ONE, Q16_ONE, 17'd0, 17'd0);
        pending_progress = {17'd0, 17'd12345, 17'd32768, 17'd65536, 17'd131071};
        load_controls(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        pending_progress = {17'd0, 17'd32768, 17'd65535, 17'd65536, 17'h1AAAA};

        // Random phases, each with fresh controls.
        for (int phase = 0; phase < 10; phase++) begin
            load_controls(pick_control(), pick_control(), pick_control(), pick_control());
            for (int n = 0; n < 83; n++) pending_progress.push_back(pick_progress());
        end
        drain();
        stim_done = 1'b1;

        $display("covered %0d results over %0d register writes", checked_count,
                 config_count);
        if (mismatch_count == 0 && expected_eased.size() == 0)
            $display("cubic_bezier_easing_top regression: pass");
        else
            $display("cubic_bezier_easing_top regression: fail");
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("cubic_bezier_easing_top regression: fail");
        $finish;
    end
endmodule
